@@ rtl/second_order_iir_lowpass_top_assert.svh @@
// Assertion macros used by the second-order IIR low-pass top level.
`ifndef SECOND_ORDER_IIR_LOWPASS_TOP_ASSERT_SVH
`define SECOND_ORDER_IIR_LOWPASS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SOIIR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("soiir assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define SOIIR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soiir assertion failed: next-cycle check");

`endif

@@ rtl/soiir_pkg.sv @@
// Package with widths, codes and types of the second-order IIR low-pass filter.
`default_nettype none
package soiir_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 18;
   localparam int FRAC_W   = 14;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + 3;
   localparam int IDX_W    = 2;

   localparam logic signed [ACC_W-1:0] ROUND_CONST = ACC_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      ACC_W'({1'b0, {(SAMPLE_W - 1){1'b1}}});
   localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

   localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd0;
   localparam logic signed [COEF_W-1:0] B1_RESET = 18'sd854;
   localparam logic signed [COEF_W-1:0] A1_RESET = -18'sd27030;
   localparam logic signed [COEF_W-1:0] A2_RESET = 18'sd11505;

   localparam logic [1:0] WARM_FIRST  = 2'd0;
   localparam logic [1:0] WARM_SECOND = 2'd1;
   localparam logic [1:0] WARM_DONE   = 2'd2;

   typedef enum logic [IDX_W-1:0] {
      IDX_B0 = 2'd0,
      IDX_B1 = 2'd1,
      IDX_A1 = 2'd2,
      IDX_A2 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] x_prev;
      logic signed [SAMPLE_W-1:0] y_prev1;
      logic signed [SAMPLE_W-1:0] y_prev2;
   } hist_type;

endpackage
`default_nettype wire

@@ rtl/soiir_if.sv @@
// Channel interfaces for samples in, samples out and coefficient writes.
`default_nettype none
interface soiir_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [soiir_pkg::SAMPLE_W-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface soiir_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [soiir_pkg::SAMPLE_W-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

interface soiir_csr_if;
   logic                                valid;
   logic                                ready;
   logic [soiir_pkg::IDX_W-1:0]         index;
   logic signed [soiir_pkg::COEF_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/soiir_csr.sv @@
// Coefficient register bank written through the configuration channel.
`default_nettype none
module soiir_csr (
   input  wire                      clock,
   input  wire                      reset,
   soiir_csr_if.sink                csr_ch,
   output soiir_pkg::coef_set_type  coef
);

   soiir_pkg::coef_set_type coef_ff;
   soiir_pkg::coef_set_type coef_in;
   soiir_pkg::csr_index_type idx;

   assign csr_ch.ready = 1'b1;
   assign idx          = soiir_pkg::csr_index_type'(csr_ch.index);
   assign coef         = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_ch.valid) begin
         unique case (idx)
            soiir_pkg::IDX_B0: coef_in.b0 = csr_ch.data;
            soiir_pkg::IDX_B1: coef_in.b1 = csr_ch.data;
            soiir_pkg::IDX_A1: coef_in.a1 = csr_ch.data;
            soiir_pkg::IDX_A2: coef_in.a2 = csr_ch.data;
            default:           coef_in    = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= soiir_pkg::B0_RESET;
         coef_ff.b1 <= soiir_pkg::B1_RESET;
         coef_ff.a1 <= soiir_pkg::A1_RESET;
         coef_ff.a2 <= soiir_pkg::A2_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/soiir_mac.sv @@
// Four-product sum with round-to-nearest, arithmetic shift and saturation.
`default_nettype none
module soiir_mac (
   input  soiir_pkg::coef_set_type              coef,
   input  soiir_pkg::hist_type                  hist,
   output logic signed [soiir_pkg::SAMPLE_W-1:0] y
);

   logic signed [soiir_pkg::PROD_W-1:0] p_b0;
   logic signed [soiir_pkg::PROD_W-1:0] p_b1;
   logic signed [soiir_pkg::PROD_W-1:0] p_a1;
   logic signed [soiir_pkg::PROD_W-1:0] p_a2;
   logic signed [soiir_pkg::ACC_W-1:0]  acc;
   logic signed [soiir_pkg::ACC_W-1:0]  shr;

   assign p_b0 = coef.b0 * hist.x;
   assign p_b1 = coef.b1 * hist.x_prev;
   assign p_a1 = coef.a1 * hist.y_prev1;
   assign p_a2 = coef.a2 * hist.y_prev2;

   assign acc = soiir_pkg::ACC_W'(p_b0) + soiir_pkg::ACC_W'(p_b1)
              - soiir_pkg::ACC_W'(p_a1) - soiir_pkg::ACC_W'(p_a2)
              + soiir_pkg::ROUND_CONST;
   assign shr = acc >>> soiir_pkg::FRAC_W;

   always_comb begin
      if (shr > soiir_pkg::SAT_MAX) begin
         y = soiir_pkg::SAT_MAX[soiir_pkg::SAMPLE_W-1:0];
      end else if (shr < soiir_pkg::SAT_MIN) begin
         y = soiir_pkg::SAT_MIN[soiir_pkg::SAMPLE_W-1:0];
      end else begin
         y = shr[soiir_pkg::SAMPLE_W-1:0];
      end
   end

endmodule
`default_nettype wire

@@ rtl/second_order_iir_lowpass_top.sv @@
// A transferred sample waits in the input stage register; when that stage advances, its result
// is loaded into the result register. Throughput: one sample per cycle unless the result
// channel stalls, limited by the four-product sum feeding the output history. The result
// register is freed as the next result is loaded. Reset (synchronous, active high) empties both
// stages, clears the warm-up counter and the sample history, and loads the default coefficients.
`default_nettype none
module second_order_iir_lowpass_top (
   input  wire          clock,
   input  wire          reset,
   soiir_req_if.sink    req_ch,
   soiir_rsp_if.source  rsp_ch,
   soiir_csr_if.sink    csr_ch
);

   `include "second_order_iir_lowpass_top_assert.svh"

   soiir_pkg::coef_set_type coef;
   soiir_pkg::hist_type     hist;
   logic signed [soiir_pkg::SAMPLE_W-1:0] mac_y;

   logic                                  s1_valid_ff, s1_valid_in;
   logic signed [soiir_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic                                  out_valid_ff, out_valid_in;
   logic signed [soiir_pkg::SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic [1:0]                            warm_ff, warm_in;
   logic signed [soiir_pkg::SAMPLE_W-1:0] ip_ff, ip_in;
   logic signed [soiir_pkg::SAMPLE_W-1:0] op1_ff, op1_in;
   logic signed [soiir_pkg::SAMPLE_W-1:0] op2_ff, op2_in;
   logic                                  req_xfer;
   logic                                  s1_adv;
   logic                                  first_adv;

   soiir_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .coef   (coef)
   );

   assign hist.x       = s1_sample_ff;
   assign hist.x_prev  = ip_ff;
   assign hist.y_prev1 = op1_ff;
   assign hist.y_prev2 = op2_ff;

   soiir_mac u_mac (
      .coef (coef),
      .hist (hist),
      .y    (mac_y)
   );

   assign s1_adv            = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign first_adv         = s1_adv && (warm_ff == soiir_pkg::WARM_FIRST);
   assign req_ch.ready      = !s1_valid_ff || s1_adv;
   assign req_xfer          = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample_out = out_sample_ff;

   always_comb begin
      s1_valid_in   = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in  = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_sample_in = out_sample_ff;
      warm_in       = warm_ff;
      ip_in         = ip_ff;
      op1_in        = op1_ff;
      op2_in        = op2_ff;
      if (s1_adv) begin
         ip_in = s1_sample_ff;
         case (warm_ff)
            soiir_pkg::WARM_FIRST: begin
               out_sample_in = s1_sample_ff;
               op1_in        = s1_sample_ff;
               warm_in       = soiir_pkg::WARM_SECOND;
            end
            soiir_pkg::WARM_SECOND: begin
               out_sample_in = s1_sample_ff;
               op2_in        = op1_ff;
               op1_in        = s1_sample_ff;
               warm_in       = soiir_pkg::WARM_DONE;
            end
            default: begin
               out_sample_in = mac_y;
               op2_in        = op1_ff;
               op1_in        = mac_y;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         warm_ff      <= soiir_pkg::WARM_FIRST;
         ip_ff        <= '0;
         op1_ff       <= '0;
         op2_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         warm_ff      <= warm_in;
         ip_ff        <= ip_in;
         op1_ff       <= op1_in;
         op2_ff       <= op2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sample_ff <= req_ch.sample_in;
      end
      out_sample_ff <= out_sample_in;
   end

   `SOIIR_ASSERT_NEXT(a_warm_first_pass, clock, reset, first_adv, out_sample_ff == ip_ff)
   `SOIIR_ASSERT_NEXT(a_hist_tracks_out, clock, reset, s1_adv, op1_ff == out_sample_ff)
   `SOIIR_ASSERT_NEXT(a_prev_input, clock, reset, s1_adv, ip_ff == $past(s1_sample_ff))
   `SOIIR_ASSERT_NOW(a_ready_when_empty, clock, reset, !s1_valid_ff, req_ch.ready)

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the second-order IIR low-pass filter with random stalls on the sample channels.
`timescale 1ns / 100ps
module tb_top;

   typedef logic signed [soiir_pkg::SAMPLE_W-1:0] sample_type;
   typedef logic signed [soiir_pkg::COEF_W-1:0]   coef_type;

   typedef enum logic [1:0] {
      STEP_SAMPLE,
      STEP_CSR,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type            kind;
      sample_type               sample;
      soiir_pkg::csr_index_type index;
      coef_type                 data;
   } plan_step_type;

   localparam sample_type SAMPLE_MAX  = {1'b0, {(soiir_pkg::SAMPLE_W - 1){1'b1}}};
   localparam sample_type SAMPLE_MIN  = {1'b1, {(soiir_pkg::SAMPLE_W - 1){1'b0}}};
   localparam coef_type   COEF_MAX    = {1'b0, {(soiir_pkg::COEF_W - 1){1'b1}}};
   localparam coef_type   COEF_MIN    = {1'b1, {(soiir_pkg::COEF_W - 1){1'b0}}};
   localparam int         SETTLE_CYCLES = 4;
   localparam int         PHASES        = 10;
   localparam int         PHASE_ITEMS   = 115;

   logic clock = 1'b0;
   logic reset = 1'b1;

   soiir_req_if req_if ();
   soiir_rsp_if rsp_if ();
   soiir_csr_if csr_if ();

   second_order_iir_lowpass_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   plan_step_type work_plan[$];
   sample_type    pending_outputs[$];
   int            fail_count = 0;

   // Filter state as the bench sees it.
   soiir_pkg::coef_set_type gains;
   logic [1:0]              warm_taken;
   sample_type              x_last;
   sample_type              y_last1;
   sample_type              y_last2;

   task automatic compute_filter_output(input sample_type x, output sample_type y);
      longint acc;
      longint q;
      if (warm_taken == soiir_pkg::WARM_FIRST) begin
         y          = x;
         x_last     = x;
         y_last1    = x;
         warm_taken = soiir_pkg::WARM_SECOND;
      end else if (warm_taken == soiir_pkg::WARM_SECOND) begin
         y          = x;
         y_last2    = y_last1;
         y_last1    = x;
         x_last     = x;
         warm_taken = soiir_pkg::WARM_DONE;
      end else begin
         acc = longint'($signed(gains.b0)) * longint'(x)
             + longint'($signed(gains.b1)) * longint'(x_last)
             - longint'($signed(gains.a1)) * longint'(y_last1)
             - longint'($signed(gains.a2)) * longint'(y_last2);
         acc = acc + (longint'(1) <<< (soiir_pkg::FRAC_W - 1));
         q   = acc >>> soiir_pkg::FRAC_W;
         if (q > longint'(SAMPLE_MAX)) begin
            q = longint'(SAMPLE_MAX);
         end
         if (q < longint'(SAMPLE_MIN)) begin
            q = longint'(SAMPLE_MIN);
         end
         y       = sample_type'(q);
         x_last  = x;
         y_last2 = y_last1;
         y_last1 = y;
      end
   endtask

   // Prediction on every accepted transfer and comparison of every result.
   sample_type predicted;
   sample_type wanted;

   always @(posedge clock) begin
      if (reset) begin
         gains.b0   = soiir_pkg::B0_RESET;
         gains.b1   = soiir_pkg::B1_RESET;
         gains.a1   = soiir_pkg::A1_RESET;
         gains.a2   = soiir_pkg::A2_RESET;
         warm_taken = soiir_pkg::WARM_FIRST;
         x_last     = '0;
         y_last1    = '0;
         y_last2    = '0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (soiir_pkg::csr_index_type'(csr_if.index))
               soiir_pkg::IDX_B0: gains.b0 = csr_if.data;
               soiir_pkg::IDX_B1: gains.b1 = csr_if.data;
               soiir_pkg::IDX_A1: gains.a1 = csr_if.data;
               soiir_pkg::IDX_A2: gains.a2 = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            compute_filter_output(req_if.sample_in, predicted);
            pending_outputs.push_back(predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_outputs.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result %0d with nothing pending", rsp_if.sample_out);
               end
               fail_count++;
            end else begin
               wanted = pending_outputs.pop_front();
               if (rsp_if.sample_out !== wanted) begin
                  if (fail_count < 10) begin
                     $display("sample_out mismatch: expected %0d, actual %0d",
                              wanted, rsp_if.sample_out);
                  end
                  fail_count++;
               end
            end
         end
      end
   end

   // Sender: bursts of transfers with random gaps; writes wait until the filter is idle.
   int   burst_left;
   int   gap_left;
   int   quiet_cycles;
   logic idle_now;
   logic launch_req;
   logic launch_csr;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_if.valid <= 1'b0;
         burst_left   <= 1;
         gap_left     <= 0;
         quiet_cycles <= 0;
      end else begin
         idle_now = !req_if.valid && !csr_if.valid && (pending_outputs.size() == 0);
         if (!idle_now) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles < SETTLE_CYCLES) begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (!(req_if.valid && !req_if.ready) && !(csr_if.valid && !csr_if.ready)) begin
            launch_req = 1'b0;
            launch_csr = 1'b0;
            if (work_plan.size() != 0) begin
               if (work_plan[0].kind == STEP_SAMPLE) begin
                  if (gap_left != 0) begin
                     gap_left <= gap_left - 1;
                  end else begin
                     req_if.sample_in <= work_plan[0].sample;
                     launch_req = 1'b1;
                     void'(work_plan.pop_front());
                     if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                           0, 1, 2: gap_left <= 0;
                           9:       gap_left <= $urandom_range(12, 30);
                           default: gap_left <= $urandom_range(1, 8);
                        endcase
                     end else begin
                        burst_left <= burst_left - 1;
                     end
                  end
               end else if (idle_now && quiet_cycles >= SETTLE_CYCLES) begin
                  if (work_plan[0].kind == STEP_CSR) begin
                     csr_if.index <= work_plan[0].index;
                     csr_if.data  <= work_plan[0].data;
                     launch_csr = 1'b1;
                  end
                  void'(work_plan.pop_front());
               end
            end
            req_if.valid <= launch_req;
            csr_if.valid <= launch_csr;
         end
      end
   end

   // Receiver: ready follows a rotating pattern that is replaced now and then.
   logic [15:0] stall_pattern;
   int          pattern_age;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         stall_pattern <= '1;
         pattern_age   <= 0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= '1;
               1:       stall_pattern <= 16'($urandom) | 16'h0001;
               2:       stall_pattern <= 16'($urandom | $urandom) | 16'h0001;
               default: stall_pattern <= 16'($urandom & $urandom) | 16'h0001;
            endcase
            pattern_age <= $urandom_range(16, 96);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_age   <= pattern_age - 1;
         end
         rsp_if.ready <= stall_pattern[0];
      end
   end

   task automatic add_sample(input sample_type s);
      plan_step_type step;
      step.kind   = STEP_SAMPLE;
      step.sample = s;
      step.index  = soiir_pkg::IDX_B0;
      step.data   = '0;
      work_plan.push_back(step);
   endtask

   task automatic add_gains(input coef_type b0, input coef_type b1,
                            input coef_type a1, input coef_type a2);
      plan_step_type step;
      step.kind   = STEP_CSR;
      step.sample = '0;
      step.index  = soiir_pkg::IDX_B0;
      step.data   = b0;
      work_plan.push_back(step);
      step.index  = soiir_pkg::IDX_B1;
      step.data   = b1;
      work_plan.push_back(step);
      step.index  = soiir_pkg::IDX_A1;
      step.data   = a1;
      work_plan.push_back(step);
      step.index  = soiir_pkg::IDX_A2;
      step.data   = a2;
      work_plan.push_back(step);
   endtask

   plan_step_type drain_step;
   sample_type    last_sample;

   initial begin
      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      csr_if.valid     = 1'b0;
      csr_if.index     = soiir_pkg::IDX_B0;
      csr_if.data      = '0;
      rsp_if.ready     = 1'b0;

      // Default gains: two warm-up samples at the extremes, then filtered extremes and values around zero.
      add_sample(SAMPLE_MAX);
      add_sample(SAMPLE_MIN);
      add_sample(SAMPLE_MAX);
      add_sample(SAMPLE_MAX);
      add_sample(SAMPLE_MIN);
      add_sample('0);
      add_sample(-sample_type'(1));
      add_sample(sample_type'(1));

      // Unit gain in the last fraction bit exposes rounding, including ties.
      add_gains(coef_type'(1), '0, '0, '0);
      add_sample(sample_type'(8192));
      add_sample(-sample_type'(8192));
      add_sample(-sample_type'(8193));
      add_sample(sample_type'(8191));

      // Extreme gains drive the output into both saturation bounds.
      add_gains(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
      repeat (3) add_sample(SAMPLE_MAX);
      repeat (3) add_sample(SAMPLE_MIN);

      last_sample = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 6)
            0: add_gains(soiir_pkg::B0_RESET, soiir_pkg::B1_RESET,
                         soiir_pkg::A1_RESET, soiir_pkg::A2_RESET);
            1: add_gains(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
            2: add_gains(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
            3: add_gains(coef_type'($urandom), coef_type'($urandom),
                         coef_type'($urandom), coef_type'($urandom));
            4: add_gains(coef_type'($urandom_range(0, 2000)),
                         coef_type'($urandom_range(0, 2000)),
                         coef_type'(-int'($urandom_range(16000, 32000))),
                         coef_type'($urandom_range(4000, 15000)));
            default: add_gains(coef_type'(16384), coef_type'($urandom_range(0, 3)), '0,
                               coef_type'(-int'($urandom_range(0, 3))));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2) begin
               drain_step.kind   = STEP_DRAIN;
               drain_step.sample = '0;
               drain_step.index  = soiir_pkg::IDX_B0;
               drain_step.data   = '0;
               work_plan.push_back(drain_step);
            end
            case ($urandom_range(0, 9))
               0, 1, 2: last_sample = sample_type'($urandom);
               3, 4, 5: last_sample = sample_type'(int'($urandom_range(0, 8192)) - 4096);
               6: begin
                  case ($urandom_range(0, 3))
                     0:       last_sample = SAMPLE_MAX;
                     1:       last_sample = SAMPLE_MIN;
                     2:       last_sample = '0;
                     default: last_sample = -sample_type'(1);
                  endcase
               end
               7: ;
               default: last_sample =
                  sample_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            endcase
            add_sample(last_sample);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (work_plan.size() == 0);
      @(posedge clock);
      wait (!req_if.valid && !csr_if.valid);
      wait (pending_outputs.size() == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_outputs.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/soiir_pkg.sv
rtl/soiir_if.sv
rtl/soiir_csr.sv
rtl/soiir_mac.sv
rtl/second_order_iir_lowpass_top.sv
bench/tb_top.sv
